// ===== src/nkf_pkg.sv =====
// Shared types, constants and the control program of the NK landscape scorer.
package nkf_pkg;

  // Fixed field widths
  localparam int VALUE_BITS = 16;
  localparam int CNT_W      = 7;
  localparam int WIN_W      = 4;
  localparam int SUM_W      = VALUE_BITS + CNT_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int TOTAL_W    = 20;
  localparam int TT_W       = TOTAL_W + 1;
  localparam logic [TT_W-1:0] TOTAL_MAX = TT_W'((1 << TOTAL_W) - 1);

  // Configuration register indexes
  localparam logic REG_SITE_COUNT  = 1'b0;
  localparam logic REG_WINDOW_SIZE = 1'b1;

  // Input word kinds
  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_BIT   = 1'b1;

  // Program counter and step addresses
  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t STEP_FETCH     = 3'd0;
  localparam upc_t STEP_ADD_BIT   = 3'd1;
  localparam upc_t STEP_WRAP_TEST = 3'd2;
  localparam upc_t STEP_WRAP_READ = 3'd3;
  localparam upc_t STEP_WRAP_ADD  = 3'd4;
  localparam upc_t STEP_DIV_INIT  = 3'd5;
  localparam upc_t STEP_DIV       = 3'd6;
  localparam upc_t STEP_EMIT      = 3'd7;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FETCH,
    OP_ADD_BIT,
    OP_WRAP,
    OP_ADD,
    OP_DIV_INIT,
    OP_DIV,
    OP_EMIT
  } op_t;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NEXT,
    C_NO_BIT,
    C_NOT_LAST,
    C_WRAP_DONE,
    C_WRAP_MORE,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic no_bit;
    logic not_last;
    logic wrap_done;
    logic div_more;
    logic out_busy;
  } status_t;

  // Control store
  function automatic ctrl_t ucode(upc_t step);
    ctrl_t w;
    w = '{accept: 1'b0, op: OP_NONE, cond: C_NEXT, target: STEP_FETCH};
    case (step)
      STEP_FETCH:     w = '{accept: 1'b1, op: OP_FETCH, cond: C_NO_BIT, target: STEP_FETCH};
      STEP_ADD_BIT:   w = '{accept: 1'b0, op: OP_ADD_BIT, cond: C_NOT_LAST,
                            target: STEP_FETCH};
      STEP_WRAP_TEST: w = '{accept: 1'b0, op: OP_NONE, cond: C_WRAP_DONE,
                            target: STEP_DIV_INIT};
      STEP_WRAP_READ: w = '{accept: 1'b0, op: OP_WRAP, cond: C_NEXT, target: STEP_WRAP_ADD};
      STEP_WRAP_ADD:  w = '{accept: 1'b0, op: OP_ADD, cond: C_WRAP_MORE,
                            target: STEP_WRAP_READ};
      STEP_DIV_INIT:  w = '{accept: 1'b0, op: OP_DIV_INIT, cond: C_NEXT, target: STEP_DIV};
      STEP_DIV:       w = '{accept: 1'b0, op: OP_DIV, cond: C_DIV_MORE, target: STEP_DIV};
      // last step falls through to fetch by counter wrap
      STEP_EMIT:      w = '{accept: 1'b0, op: OP_EMIT, cond: C_OUT_BUSY, target: STEP_EMIT};
      default:        w = '{accept: 1'b0, op: OP_NONE, cond: C_NEXT, target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== src/nkf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nkf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/nkf_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module nkf_useq (
  input  logic             clk,
  input  logic             rst,
  input  nkf_pkg::status_t status,
  output nkf_pkg::ctrl_t   ctrl
);
  import nkf_pkg::*;

  upc_t upc;
  upc_t upc_next;
  logic jump;

  // Fetch the control word for the current step
  always_comb begin
    ctrl = ucode(upc);
  end

  // Evaluate the jump condition and pick the next step
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:      jump = 1'b0;
      C_NO_BIT:    jump = status.no_bit;
      C_NOT_LAST:  jump = status.not_last;
      C_WRAP_DONE: jump = status.wrap_done;
      C_WRAP_MORE: jump = !status.wrap_done;
      C_DIV_MORE:  jump = status.div_more;
      C_OUT_BUSY:  jump = status.out_busy;
      default:     jump = 1'b0;
    endcase
    upc_next = jump ? ctrl.target : upc + UPC_W'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // A fetch step is only left for a genome bit
  a_fetch_leaves_on_bit: assert property (@(posedge clk) disable iff (rst)
    (upc == STEP_FETCH && upc_next != STEP_FETCH) |-> !status.no_bit)
    else $error("fetch step left without a genome bit");

endmodule

// ===== src/nk_landscape_fitness.sv =====
// NK landscape scorer: table load, per-site lookups, wrap sites, mean and trait total.
// Table word: accepted in the fetch step. Genome bit: fetch step with table read, then add step.
// Last bit of a genome: one table read per wrap site and a 23-step bit-serial divider
// come before the result register loads.
// Result sits in an output register; the next genome proceeds while it waits, up to its emit step.
// Synchronous reset clears control and sums, sets both registers to 1; table is undefined.
module nk_landscape_fitness #(
  parameter int MAX_SITES  = 64,
  parameter int MAX_WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [5:0]  site,
  input  logic [7:0]  pattern,
  input  logic [15:0] table_value,
  input  logic        genome_bit,
  input  logic        final_trait,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] genome_score,
  output logic [19:0] total_score,
  output logic        last_of_organism
);
  import nkf_pkg::*;

  localparam int DEPTH  = MAX_SITES << MAX_WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers
  logic [CNT_W-1:0] site_count;
  logic [WIN_W-1:0] window_size;
  logic [CNT_W-1:0] n_eff;
  logic [WIN_W-1:0] k_eff;

  // Genome state
  logic [MAX_WINDOW-1:0] window_bits;
  logic [MAX_WINDOW-1:0] head_bits;
  logic [CNT_W-1:0]      bit_count;
  logic [SUM_W-1:0]      site_sum;
  logic [TT_W-1:0]       trait_total;
  logic                  hit;
  logic                  final_q;
  logic [WIN_W-1:0]      wrap_cnt;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [CNT_W-1:0]      rem;

  // Sequencer link
  ctrl_t   ctrl;
  status_t status;

  // Datapath signals
  logic                  take;
  logic                  take_bit;
  logic                  tab_we;
  logic                  cfg_clear;
  logic                  emit_fire;
  logic                  bit_hit;
  logic [MAX_WINDOW-1:0] win_shift;
  logic [MAX_WINDOW-1:0] win_wrap;
  logic [CNT_W-1:0]      bit_site;
  logic [MAX_WINDOW-1:0] bit_pat;
  logic [CNT_W-1:0]      wrap_site;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic                  re;
  logic [VALUE_BITS-1:0] rdata;
  logic [CNT_W:0]        trial;
  logic                  trial_ge;
  logic [TT_W-1:0]       tt_sum;
  logic [TT_W-1:0]       tt_sat;

  function automatic logic [ADDR_W-1:0] tab_addr(logic [CNT_W-1:0] s,
                                                 logic [MAX_WINDOW-1:0] p);
    logic [ADDR_W-1:0] a;
    a = (ADDR_W'(s) << MAX_WINDOW) | ADDR_W'(p);
    return a;
  endfunction

  nkf_useq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  nkf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (waddr),
    .wdata (table_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Clamp site count and window to their usable ranges
  always_comb begin
    if (site_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(site_count) > MAX_SITES) begin
      n_eff = CNT_W'(MAX_SITES);
    end else begin
      n_eff = site_count;
    end
    k_eff = window_size;
    if (int'(window_size) > MAX_WINDOW) begin
      k_eff = WIN_W'(MAX_WINDOW);
    end
    if (CNT_W'(k_eff) > n_eff) begin
      k_eff = WIN_W'(n_eff);
    end
  end

  // Handshake and write strobes
  assign in_ready  = ctrl.accept;
  assign take      = in_valid && ctrl.accept;
  assign take_bit  = take && (kind == KIND_BIT);
  assign tab_we    = take && (kind == KIND_TABLE) && (int'(site) < MAX_SITES);
  assign waddr     = tab_addr(CNT_W'(site), MAX_WINDOW'(pattern));
  assign cfg_clear = cfg_we && (cfg_index == REG_SITE_COUNT || cfg_index == REG_WINDOW_SIZE);
  assign emit_fire = (ctrl.op == OP_EMIT) && !status.out_busy;

  // Window shift and table addresses for a new bit and for a wrap site
  always_comb begin
    bit_hit   = ({1'b0, bit_count} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(k_eff);
    win_shift = (window_bits >> 1) | (MAX_WINDOW'(genome_bit) << (k_eff - WIN_W'(1)));
    win_wrap  = (window_bits >> 1) | (MAX_WINDOW'(head_bits[0]) << (k_eff - WIN_W'(1)));
    if (k_eff == '0) begin
      bit_site = bit_count;
      bit_pat  = '0;
    end else begin
      bit_site = bit_count - CNT_W'(k_eff) + CNT_W'(1);
      bit_pat  = win_shift;
    end
    wrap_site = n_eff - CNT_W'(k_eff) + CNT_W'(1) + CNT_W'(wrap_cnt);
    if (ctrl.op == OP_WRAP) begin
      raddr = tab_addr(wrap_site, win_wrap);
    end else begin
      raddr = tab_addr(bit_site, bit_pat);
    end
    re = (take_bit && bit_hit) || (ctrl.op == OP_WRAP);
  end

  // Divider step and trait total with saturation
  always_comb begin
    trial    = {rem, site_sum[SUM_W-1]};
    trial_ge = trial >= {1'b0, n_eff};
    tt_sum   = trait_total + TT_W'(site_sum[VALUE_BITS-1:0]);
    tt_sat   = (tt_sum > TOTAL_MAX) ? TOTAL_MAX : tt_sum;
  end

  // Status back to the sequencer
  always_comb begin
    status.no_bit    = !take_bit;
    status.not_last  = ({1'b0, bit_count} + (CNT_W + 1)'(1)) < {1'b0, n_eff};
    status.wrap_done = ({1'b0, wrap_cnt} + (WIN_W + 1)'(1)) >= {1'b0, k_eff};
    status.div_more  = div_cnt != DIV_CNT_W'(1);
    status.out_busy  = out_valid && !out_ready;
  end

  // Datapath registers driven by the current control word
  always_ff @(posedge clk) begin
    if (rst) begin
      site_count  <= CNT_W'(1);
      window_size <= WIN_W'(1);
      window_bits <= '0;
      head_bits   <= '0;
      bit_count   <= '0;
      site_sum    <= '0;
      trait_total <= '0;
      hit         <= 1'b0;
      final_q     <= 1'b0;
      wrap_cnt    <= '0;
      div_cnt     <= '0;
      rem         <= '0;
    end else if (cfg_clear) begin
      // write a register and drop the genome in progress
      if (cfg_index == REG_SITE_COUNT) begin
        site_count <= cfg_data;
      end else begin
        window_size <= cfg_data[WIN_W-1:0];
      end
      window_bits <= '0;
      head_bits   <= '0;
      bit_count   <= '0;
      site_sum    <= '0;
      wrap_cnt    <= '0;
    end else begin
      unique case (ctrl.op)
        OP_FETCH: begin
          if (take_bit) begin
            if (k_eff != '0) begin
              window_bits <= win_shift;
            end
            if (!bit_hit) begin
              head_bits <= head_bits | (MAX_WINDOW'(genome_bit) << bit_count);
            end
            hit     <= bit_hit;
            final_q <= final_trait;
          end
        end
        OP_ADD_BIT: begin
          if (hit) begin
            site_sum <= site_sum + SUM_W'(rdata);
          end
          bit_count <= bit_count + CNT_W'(1);
          wrap_cnt  <= '0;
        end
        OP_WRAP: begin
          window_bits <= win_wrap;
          head_bits   <= head_bits >> 1;
          wrap_cnt    <= wrap_cnt + WIN_W'(1);
        end
        OP_ADD: begin
          site_sum <= site_sum + SUM_W'(rdata);
        end
        OP_DIV_INIT: begin
          div_cnt <= DIV_CNT_W'(SUM_W);
          rem     <= '0;
        end
        OP_DIV: begin
          // restoring step: remainder takes the next dividend bit, quotient shifts in
          rem      <= trial_ge ? CNT_W'(trial - {1'b0, n_eff}) : trial[CNT_W-1:0];
          site_sum <= {site_sum[SUM_W-2:0], trial_ge};
          div_cnt  <= div_cnt - DIV_CNT_W'(1);
        end
        OP_EMIT: begin
          if (emit_fire) begin
            trait_total <= final_q ? '0 : tt_sat;
            window_bits <= '0;
            head_bits   <= '0;
            bit_count   <= '0;
            site_sum    <= '0;
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      genome_score     <= site_sum[VALUE_BITS-1:0];
      total_score      <= tt_sat[TOTAL_W-1:0];
      last_of_organism <= final_q;
    end
  end

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit_fire))
    else $error("result word appeared without an emit step");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= n_eff)
    else $error("bit count ran past the site count");

  a_emit_clears_genome: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (bit_count == '0 && site_sum == '0))
    else $error("genome state not cleared after a result");

endmodule
